[src/smm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants for the segment merge max sum unit
// Field widths of the stream and configuration ports, item kinds, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package smm_pkg;

  // Fixed field widths on the ports
  localparam int POS_BITS      = 10;
  localparam int VALUE_IN_BITS = 32;
  localparam int SUM_OUT_BITS  = 42;
  localparam int LEN_OUT_BITS  = 11;
  localparam int ALEN_BITS     = 11;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 96;

  // Default sizing
  localparam int DEF_MAX_POSITIONS = 1024;
  localparam int DEF_VALUE_BITS    = 32;
  localparam int ALEN_RESET        = 1024;

  // Item kinds carried in the input tuser
  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SUM1,
    S_SUM2,
    S_WRL,
    S_WRR,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic clr_en;
    logic rd_en;
    logic sum1_en;
    logic sum2_en;
    logic wr_left;
    logic wr_right;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic pos_err;
    logic out_free;
  } dp_stat_t;

endpackage

[src/smm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ctrl: sequencing state machine
// Steps each item through clear sweep, neighbor read, two saturating adds,
// two endpoint writes and the result load.
// ----------------------------------------------------------------------------
module smm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic              s_axis_tuser,
  input  smm_pkg::dp_stat_t stat,
  output smm_pkg::ctrl_cmd_t cmd
);

  smm_pkg::state_t state;
  smm_pkg::state_t state_next;

  // State register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smm_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      smm_pkg::S_CLEAR: begin
        if (stat.clr_last) state_next = smm_pkg::S_IDLE;
      end
      smm_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == smm_pkg::CMD_CLEAR) state_next = smm_pkg::S_CLEAR;
          else state_next = smm_pkg::S_READ;
        end
      end
      smm_pkg::S_READ: begin
        if (stat.pos_err) state_next = smm_pkg::S_DONE;
        else state_next = smm_pkg::S_SUM1;
      end
      smm_pkg::S_SUM1: state_next = smm_pkg::S_SUM2;
      smm_pkg::S_SUM2: state_next = smm_pkg::S_WRL;
      smm_pkg::S_WRL:  state_next = smm_pkg::S_WRR;
      smm_pkg::S_WRR:  state_next = smm_pkg::S_DONE;
      smm_pkg::S_DONE: begin
        if (stat.out_free) state_next = smm_pkg::S_IDLE;
      end
      default: state_next = smm_pkg::S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      smm_pkg::S_CLEAR: cmd.clr_en = 1'b1;
      smm_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load_in   = s_axis_tvalid;
      end
      smm_pkg::S_READ: cmd.rd_en    = 1'b1;
      smm_pkg::S_SUM1: cmd.sum1_en  = 1'b1;
      smm_pkg::S_SUM2: cmd.sum2_en  = 1'b1;
      smm_pkg::S_WRL:  cmd.wr_left  = 1'b1;
      smm_pkg::S_WRR:  cmd.wr_right = 1'b1;
      smm_pkg::S_DONE: cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[src/smm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_datapath: run store, merge arithmetic and result register
// Holds the run store (length and sum at each run endpoint), the running
// best sum, the length register and the output register.
// ----------------------------------------------------------------------------
module smm_datapath #(
  parameter int MAX_POSITIONS = smm_pkg::DEF_MAX_POSITIONS,
  parameter int VALUE_BITS    = smm_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  smm_pkg::ctrl_cmd_t                 cmd,
  output smm_pkg::dp_stat_t                  stat,
  input  logic [smm_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  input  logic                               cfg_valid,
  input  logic [smm_pkg::ALEN_BITS-1:0]      cfg_data,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [smm_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  output logic                               m_axis_tuser
);

  localparam int AW = $clog2(MAX_POSITIONS);
  localparam int LW = $clog2(MAX_POSITIONS + 1);
  localparam int SW = $clog2(MAX_POSITIONS) + VALUE_BITS;
  localparam int EW = SW + LW;
  localparam int PW = (LW > smm_pkg::POS_BITS + 1) ? LW : smm_pkg::POS_BITS + 1;
  localparam logic [63:0] SUM_LIMIT64 =
    64'(MAX_POSITIONS) * ((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [SW-1:0] SUM_LIMIT = SW'(SUM_LIMIT64);
  localparam logic [31:0] VMASK = (VALUE_BITS >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << VALUE_BITS) - 64'd1);
  localparam int ALEN_RST = (MAX_POSITIONS < smm_pkg::ALEN_RESET) ?
                            MAX_POSITIONS : smm_pkg::ALEN_RESET;

  // Run store: {length, sum} per position
  logic [EW-1:0] mem [MAX_POSITIONS];

  logic [LW-1:0]                   alen;
  logic [smm_pkg::POS_BITS-1:0]    pos_q;
  logic [SW-1:0]                   val_q;
  logic [EW-1:0]                   rd_l;
  logic [EW-1:0]                   rd_r;
  logic                            has_l;
  logic                            has_r;
  logic [SW-1:0]                   part;
  logic [SW-1:0]                   sum;
  logic [LW-1:0]                   len;
  logic [AW-1:0]                   lend;
  logic [AW-1:0]                   rend;
  logic [SW-1:0]                   best;
  logic [AW-1:0]                   clr_cnt;
  logic [smm_pkg::SUM_OUT_BITS-1:0] out_max;
  logic [smm_pkg::SUM_OUT_BITS-1:0] out_sum;
  logic [smm_pkg::LEN_OUT_BITS-1:0] out_len;
  logic                            out_err;

  logic [PW-1:0]   pos_w;
  logic [PW-1:0]   alen_w;
  logic [PW-1:0]   cfg_w;
  logic            pos_err;
  logic [AW-1:0]   addr_l;
  logic [AW-1:0]   addr_r;
  logic [SW-1:0]   lsum;
  logic [SW-1:0]   rsum;
  logic [LW-1:0]   llen;
  logic [LW-1:0]   rlen;
  logic [SW:0]     add1;
  logic [SW:0]     add2;
  logic [LW+1:0]   len_raw;
  logic [PW-1:0]   llen_w;
  logic [PW:0]     rend_raw;
  logic [PW:0]     rend_lim;
  logic            we;
  logic [AW-1:0]   wa;
  logic [EW-1:0]   wd;

  assign pos_w   = PW'(pos_q);
  assign alen_w  = PW'(alen);
  assign cfg_w   = PW'(cfg_data);
  assign pos_err = pos_w >= alen_w;
  assign addr_l  = AW'(pos_w - PW'(1));
  assign addr_r  = AW'(pos_w + PW'(1));

  // Length register, clamped to 1..MAX_POSITIONS
  always_ff @(posedge clk) begin
    if (rst) begin
      alen <= LW'(ALEN_RST);
    end else if (cfg_valid) begin
      if (cfg_data == '0) alen <= LW'(1);
      else if (cfg_w > PW'(MAX_POSITIONS)) alen <= LW'(MAX_POSITIONS);
      else alen <= LW'(cfg_w);
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos_q <= s_axis_tdata[smm_pkg::POS_BITS-1:0];
      val_q <= SW'(s_axis_tdata[smm_pkg::POS_BITS +: smm_pkg::VALUE_IN_BITS] & VMASK);
    end
  end

  // Neighbor reads, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_l  <= mem[addr_l];
      rd_r  <= mem[addr_r];
      has_l <= pos_q != '0;
      has_r <= (pos_w + PW'(1)) < alen_w;
    end
  end

  assign lsum = has_l ? rd_l[SW-1:0] : '0;
  assign llen = has_l ? rd_l[EW-1:SW] : '0;
  assign rsum = has_r ? rd_r[SW-1:0] : '0;
  assign rlen = has_r ? rd_r[EW-1:SW] : '0;

  // Merge arithmetic
  always_comb begin
    add1     = {1'b0, val_q} + {1'b0, lsum};
    add2     = {1'b0, part} + {1'b0, rsum};
    len_raw  = (LW+2)'(1) + (LW+2)'(llen) + (LW+2)'(rlen);
    llen_w   = PW'(llen);
    rend_raw = (PW+1)'(pos_w) + (PW+1)'(rlen);
    rend_lim = (PW+1)'(alen_w - PW'(1));
  end

  // First add, merged length and both endpoints
  always_ff @(posedge clk) begin
    if (cmd.sum1_en) begin
      part <= (add1 > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : add1[SW-1:0];
      len  <= (len_raw > (LW+2)'(MAX_POSITIONS)) ? LW'(MAX_POSITIONS) : LW'(len_raw);
      lend <= (llen_w > pos_w) ? '0 : AW'(pos_w - llen_w);
      rend <= (rend_raw > rend_lim) ? AW'(rend_lim) : AW'(rend_raw);
    end
  end

  // Second add
  always_ff @(posedge clk) begin
    if (cmd.sum2_en) begin
      sum <= (add2 > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : add2[SW-1:0];
    end
  end

  // Write port: clearing sweep or endpoint writes
  always_comb begin
    we = cmd.clr_en | cmd.wr_left | cmd.wr_right;
    wa = cmd.clr_en ? clr_cnt : (cmd.wr_left ? lend : rend);
    wd = cmd.clr_en ? '0 : {len, sum};
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  // Clearing sweep counter, wraps to zero at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      if (stat.clr_last) clr_cnt <= '0;
      else clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Best sum so far
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_en) begin
      best <= '0;
    end else if (cmd.wr_left && (sum > best)) begin
      best <= sum;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_max <= smm_pkg::SUM_OUT_BITS'(best);
      out_sum <= pos_err ? '0 : smm_pkg::SUM_OUT_BITS'(sum);
      out_len <= pos_err ? '0 : smm_pkg::LEN_OUT_BITS'(len);
      out_err <= pos_err;
    end
  end

  assign m_axis_tdata = {1'b0, out_len, out_sum, out_max};
  assign m_axis_tuser = out_err;

  assign stat.clr_last = clr_cnt == AW'(MAX_POSITIONS - 1);
  assign stat.pos_err  = pos_err;
  assign stat.out_free = !m_axis_tvalid || m_axis_tready;

endmodule

[src/segment_merge_max_sum_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_merge_max_sum_unit: maximum run sum under position activation
// Each insert activates one position, merges it with the runs on either
// side and reports the merged run and the largest run sum so far.
//
// Input stream (s_axis): tuser is the item kind, 0 clears all runs and the
// best sum, 1 inserts. An insert yields one result; a clear yields none.
// Output stream (m_axis): tuser flags a position not below the array length;
// such an item changes nothing and reports the current best sum.
// Config channel (cfg_*): writes the array length, always ready; write it
// only while the block is idle.
// Sequence: an insert steps through the read, two saturating adds, two
// endpoint writes on the single write port and the result load before the
// next ready; an out-of-range insert goes from the read to the result load.
// A clear, and reset, run a sweep over the whole run store with tready low.
// The result turns valid at the result load when the output register is
// free; the input stays closed until then. While a result
// is not taken, the block finishes the next item and waits before loading.
// ----------------------------------------------------------------------------
module segment_merge_max_sum_unit #(
  parameter int MAX_POSITIONS = smm_pkg::DEF_MAX_POSITIONS,
  parameter int VALUE_BITS    = smm_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // position [9:0], value [41:10], zero fill [47:42]
  input  logic [smm_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // cmd [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // max_sum [41:0], run_sum [83:42], run_length [94:84], zero fill [95]
  output logic [smm_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // position_error [0]
  output logic                               m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smm_pkg::ALEN_BITS-1:0]      cfg_data
);

  smm_pkg::ctrl_cmd_t cmd;
  smm_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  // Sequencer
  smm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Store and arithmetic
  smm_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // Close the input right after any transfer
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input stayed open after a transfer");

  // A new result only appears while the input is closed
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input was open");

  // Rejected positions report an empty run
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[94:84] == '0) && (m_axis_tdata[83:42] == '0))
    else $error("rejected position reported a run");
`endif

endmodule
